// File: src/cc20ks_pkg.sv
// ----------------------------------------------------------------------------
// cc20ks_pkg
// Shared types, constants and the quarter-round function for the ChaCha20
// keystream block unit.
// ----------------------------------------------------------------------------
package cc20ks_pkg;

  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 7;
  localparam int VBYTES_W    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ROUNDS      = 20;
  localparam int RND_W       = $clog2(ROUNDS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  localparam logic [COUNT_W-1:0] BLOCK_BYTES = 7'd64;
  localparam logic [COUNT_W-1:0] WORD_BYTES  = 7'd8;

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_01     = 3'd0,
    REG_KEY_23     = 3'd1,
    REG_KEY_45     = 3'd2,
    REG_KEY_67     = 3'd3,
    REG_NONCE_01   = 3'd4,
    REG_NONCE_2    = 3'd5,
    REG_INIT_CTR   = 3'd6,
    REG_UNUSED     = 3'd7
  } cfg_reg_t;

  // One queued block request: saturated byte count and its counter value.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    word_t              counter;
  } job_t;

  // Key and nonce as seen by the block core.
  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
  } key_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } core_state_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic quad_t quarter(input word_t a_in, input word_t b_in,
                                    input word_t c_in, input word_t d_in);
    word_t a, b, c, d;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter = '{a: a, b: b, c: c, d: d};
  endfunction

endpackage

// File: src/cc20ks_front.sv
// ----------------------------------------------------------------------------
// cc20ks_front
// Accepts requests, applies restart, saturates the byte count and tags each
// non-empty request with its block counter value before queueing it.
// ----------------------------------------------------------------------------
module cc20ks_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [cc20ks_pkg::COUNT_W-1:0] byte_count,
  input  logic                        restart,
  input  cc20ks_pkg::word_t           initial_counter,
  input  logic                        queue_full,
  output logic                        push,
  output cc20ks_pkg::job_t            push_job
);
  import cc20ks_pkg::*;

  word_t block_counter;
  word_t block_counter_next;
  word_t ctr_base;
  logic  accept;
  logic  empty_req;

  assign req_ready = !queue_full;
  assign accept    = req_valid && req_ready;
  assign empty_req = (byte_count == '0);
  assign ctr_base  = restart ? initial_counter : block_counter;
  assign push      = accept && !empty_req;

  always_comb begin
    push_job.counter = ctr_base;
    push_job.count   = (byte_count > BLOCK_BYTES) ? BLOCK_BYTES : byte_count;
    block_counter_next = block_counter;
    if (accept) begin
      block_counter_next = empty_req ? ctr_base : ctr_base + word_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else begin
      block_counter <= block_counter_next;
    end
  end

endmodule

// File: src/cc20ks_queue.sv
// ----------------------------------------------------------------------------
// cc20ks_queue
// Short first-in first-out queue of block requests between front and core.
// ----------------------------------------------------------------------------
module cc20ks_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cc20ks_pkg::job_t push_job,
  input  logic             pop,
  output cc20ks_pkg::job_t head_job,
  output logic             full,
  output logic             empty
);
  import cc20ks_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] fill;

  assign full     = (fill == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QUEUE_CW'(1);
        2'b01:   fill <= fill - QUEUE_CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/cc20ks_core.sv
// ----------------------------------------------------------------------------
// cc20ks_core
// Block core: one ChaCha20 round per cycle over four parallel quarter
// rounds, the feed-forward addition, then word-by-word output through a
// registered output stage.
// ----------------------------------------------------------------------------
module cc20ks_core (
  input  logic                            clk,
  input  logic                            rst,
  input  cc20ks_pkg::key_cfg_t            key_cfg,
  input  logic                            queue_empty,
  input  cc20ks_pkg::job_t                head_job,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [63:0]                     keystream_word,
  output logic [cc20ks_pkg::VBYTES_W-1:0] valid_bytes,
  output logic                            last_word
);
  import cc20ks_pkg::*;

  core_state_t          state;
  core_state_t          state_next;
  word_t                work [16];
  word_t                init_words [16];
  word_t                round_words [16];
  word_t                blk_ctr;
  logic [RND_W-1:0]     rnd;
  logic [COUNT_W-1:0]   remaining;
  logic [VBYTES_W-1:0]  cur_vb;
  logic [63:0]          cur_word;
  logic                 load_out;
  word_t                init_ctr;
  quad_t                q0, q1, q2, q3;

  // The counter word comes from the queue head while loading, else from the
  // copy held for the feed-forward addition.
  assign init_ctr = (state == ST_IDLE) ? head_job.counter : blk_ctr;

  always_comb begin
    init_words[0]  = SIGMA0;
    init_words[1]  = SIGMA1;
    init_words[2]  = SIGMA2;
    init_words[3]  = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      init_words[4 + i] = key_cfg.key[i];
    end
    init_words[12] = init_ctr;
    init_words[13] = key_cfg.nonce[0];
    init_words[14] = key_cfg.nonce[1];
    init_words[15] = key_cfg.nonce[2];
  end

  // Even rounds work on columns, odd rounds on diagonals.
  always_comb begin
    if (!rnd[0]) begin
      q0 = quarter(work[0], work[4], work[8],  work[12]);
      q1 = quarter(work[1], work[5], work[9],  work[13]);
      q2 = quarter(work[2], work[6], work[10], work[14]);
      q3 = quarter(work[3], work[7], work[11], work[15]);
      round_words[0] = q0.a; round_words[4] = q0.b;
      round_words[8] = q0.c; round_words[12] = q0.d;
      round_words[1] = q1.a; round_words[5] = q1.b;
      round_words[9] = q1.c; round_words[13] = q1.d;
      round_words[2] = q2.a; round_words[6] = q2.b;
      round_words[10] = q2.c; round_words[14] = q2.d;
      round_words[3] = q3.a; round_words[7] = q3.b;
      round_words[11] = q3.c; round_words[15] = q3.d;
    end else begin
      q0 = quarter(work[0], work[5], work[10], work[15]);
      q1 = quarter(work[1], work[6], work[11], work[12]);
      q2 = quarter(work[2], work[7], work[8],  work[13]);
      q3 = quarter(work[3], work[4], work[9],  work[14]);
      round_words[0] = q0.a; round_words[5] = q0.b;
      round_words[10] = q0.c; round_words[15] = q0.d;
      round_words[1] = q1.a; round_words[6] = q1.b;
      round_words[11] = q1.c; round_words[12] = q1.d;
      round_words[2] = q2.a; round_words[7] = q2.b;
      round_words[8] = q2.c; round_words[13] = q2.d;
      round_words[3] = q3.a; round_words[4] = q3.b;
      round_words[9] = q3.c; round_words[14] = q3.d;
    end
  end

  // Current output word with the bytes beyond the valid count cleared.
  always_comb begin
    cur_vb = (remaining > WORD_BYTES) ? VBYTES_W'(8) : remaining[VBYTES_W-1:0];
    for (int b = 0; b < 8; b++) begin
      if (b < 4) begin
        cur_word[8*b +: 8] = (VBYTES_W'(b) < cur_vb) ? work[0][8*b +: 8] : 8'h00;
      end else begin
        cur_word[8*b +: 8] = (VBYTES_W'(b) < cur_vb) ? work[1][8*(b-4) +: 8] : 8'h00;
      end
    end
  end

  assign load_out = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!queue_empty) begin
          pop        = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == RND_W'(ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out && remaining <= WORD_BYTES) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!queue_empty) begin
          for (int i = 0; i < 16; i++) begin
            work[i] <= init_words[i];
          end
          blk_ctr   <= head_job.counter;
          remaining <= head_job.count;
          rnd       <= '0;
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < 16; i++) begin
          work[i] <= round_words[i];
        end
        rnd <= rnd + RND_W'(1);
      end
      ST_FINAL: begin
        for (int i = 0; i < 16; i++) begin
          work[i] <= work[i] + init_words[i];
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          // Shift the next word pair down into place.
          for (int i = 0; i < 14; i++) begin
            work[i] <= work[i + 2];
          end
          remaining <= remaining - WORD_BYTES;
        end
      end
      default: begin
        rnd <= rnd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      keystream_word <= cur_word;
      valid_bytes    <= cur_vb;
      last_word      <= (remaining <= WORD_BYTES);
    end
  end

endmodule

// File: src/chacha20_keystream_block_unit.sv
// ----------------------------------------------------------------------------
// chacha20_keystream_block_unit
// ChaCha20 keystream generator: one 64-byte block per non-empty request, emitted as
// 64-bit little-endian words with a valid-byte count and a last flag.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   -----------------------------------------
//   req       req_valid/req_ready   byte_count, restart
//   out       out_valid/out_ready   keystream_word, valid_bytes, last_word
//   cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A block goes through a load step, the rounds (one round of four parallel
// quarter rounds per cycle in the core), the feed-forward addition and then
// word output, which waits on out_ready.
// The front part accepts a request whenever the two-entry queue has room, so
// requests are taken while the core is busy or the output stage is stalled.
// Reset clears the configuration registers, the block counter, the queue and
// the output valid flag; there is no clearing pass.
// The configuration port is always ready; writes are expected only while
// the unit is idle.
//
module chacha20_keystream_block_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [cc20ks_pkg::COUNT_W-1:0]    byte_count,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [63:0]                       keystream_word,
  output logic [cc20ks_pkg::VBYTES_W-1:0]   valid_bytes,
  output logic                              last_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cc20ks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cc20ks_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cc20ks_pkg::*;

  key_cfg_t key_cfg;
  word_t    initial_counter;
  logic     push;
  job_t     push_job;
  logic     pop;
  job_t     head_job;
  logic     queue_full;
  logic     queue_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers. The 64-bit registers hold the even word in the
  // low half; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg         <= '0;
      initial_counter <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_01: begin
          key_cfg.key[0] <= cfg_data[31:0];
          key_cfg.key[1] <= cfg_data[63:32];
        end
        REG_KEY_23: begin
          key_cfg.key[2] <= cfg_data[31:0];
          key_cfg.key[3] <= cfg_data[63:32];
        end
        REG_KEY_45: begin
          key_cfg.key[4] <= cfg_data[31:0];
          key_cfg.key[5] <= cfg_data[63:32];
        end
        REG_KEY_67: begin
          key_cfg.key[6] <= cfg_data[31:0];
          key_cfg.key[7] <= cfg_data[63:32];
        end
        REG_NONCE_01: begin
          key_cfg.nonce[0] <= cfg_data[31:0];
          key_cfg.nonce[1] <= cfg_data[63:32];
        end
        REG_NONCE_2: begin
          key_cfg.nonce[2] <= cfg_data[31:0];
        end
        REG_INIT_CTR: begin
          initial_counter <= cfg_data[31:0];
        end
        default: begin
          initial_counter <= initial_counter;
        end
      endcase
    end
  end

  // Front part: restart handling, count saturation and counter tagging.
  cc20ks_front u_front (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .byte_count      (byte_count),
    .restart         (restart),
    .initial_counter (initial_counter),
    .queue_full      (queue_full),
    .push            (push),
    .push_job        (push_job)
  );

  // Request queue decoupling the front from the block core.
  cc20ks_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // Back part: the rounds, the feed-forward addition and word output.
  cc20ks_core u_core (
    .clk            (clk),
    .rst            (rst),
    .key_cfg        (key_cfg),
    .queue_empty    (queue_empty),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keystream_word (keystream_word),
    .valid_bytes    (valid_bytes),
    .last_word      (last_word)
  );

endmodule
